// File: rtl/core/bucketed_hash_index_assert.svh
// Assertion macros for the bucketed hash index RTL.
`ifndef BUCKETED_HASH_INDEX_ASSERT_SVH
`define BUCKETED_HASH_INDEX_ASSERT_SVH
`ifndef SYNTHESIS
`define BHI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BHI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHI_ASSERT(label, clk, rst_n, prop, msg)
`define BHI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/bhi_pkg.sv
// Types and constants shared by the bucketed hash index.
`timescale 1ns / 1ps
package bhi_pkg;

    localparam int KEY_WORDS = 4;
    localparam int KEY_W     = 64;
    localparam int FNUM_W    = 17;
    localparam int FOFF_W    = 27;
    localparam int SLOT_W    = 14;
    localparam int STATUS_W  = 2;
    localparam int HASH_LSB  = 13;

    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

    typedef struct packed {
        logic                             valid;
        logic [KEY_WORDS-1:0][KEY_W-1:0]  key;
        logic [FNUM_W-1:0]                fnum;
        logic [FOFF_W-1:0]                foff;
    } t_entry;

endpackage

// File: rtl/core/bhi_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module bhi_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bucketed_hash_index.sv
// Top level of the bucketed hash index: slot table, probe sequencer, result register.
// Probe k (from 0) checks slot base+k, read from the table RAM; o_done is registered from the last probe.
// busy stays high from the transfer through the last probe, one slot read per cycle from
// the table RAM; no new operation is accepted while busy.
// Synchronous reset starts a clearing pass over all TABLE_DEPTH slots (8204 by default), busy high.
// o_done is a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`include "bucketed_hash_index_assert.svh"
module bucketed_hash_index #(
    parameter int BUCKET_BITS   = 10,
    parameter int LOOKUP_PROBES = 20,
    parameter int INSERT_PROBES = 19,
    parameter int WARN_PROBE    = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [bhi_pkg::KEY_W-1:0]     i_key_0,
    input  logic [bhi_pkg::KEY_W-1:0]     i_key_1,
    input  logic [bhi_pkg::KEY_W-1:0]     i_key_2,
    input  logic [bhi_pkg::KEY_W-1:0]     i_key_3,
    input  logic [bhi_pkg::FNUM_W-1:0]    i_file_number,
    input  logic [bhi_pkg::FOFF_W-1:0]    i_file_offset,
    output logic                          o_done,
    output logic [bhi_pkg::STATUS_W-1:0]  o_status,
    output logic [bhi_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [bhi_pkg::FNUM_W-1:0]    o_found_file_number,
    output logic [bhi_pkg::FOFF_W-1:0]    o_found_file_offset,
    output logic                          o_crowded
);

    import bhi_pkg::*;

    localparam int MAX_PROBES  = (LOOKUP_PROBES > INSERT_PROBES) ? LOOKUP_PROBES : INSERT_PROBES;
    localparam int TABLE_DEPTH = (((2 ** BUCKET_BITS) - 1) * 8) + MAX_PROBES;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int CW          = $clog2(MAX_PROBES + 1);
    localparam int EW          = $bits(t_entry);

    t_state r_state, n_state;

    logic [AW-1:0]                    r_clr;
    logic                             r_mode;
    logic [KEY_WORDS-1:0][KEY_W-1:0]  r_key;
    logic [FNUM_W-1:0]                r_fnum;
    logic [FOFF_W-1:0]                r_foff;
    logic [AW-1:0]                    r_base;
    logic [CW-1:0]                    r_chk;

    logic                             r_done, n_done;
    logic [STATUS_W-1:0]              r_status, n_status;
    logic [SLOT_W-1:0]                r_slot, n_slot;
    logic [FNUM_W-1:0]                r_fn_out, n_fn_out;
    logic [FOFF_W-1:0]                r_fo_out, n_fo_out;
    logic                             r_crowded, n_crowded;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    t_entry                           ram_wdata;
    logic [AW-1:0]                    ram_raddr;
    logic [EW-1:0]                    ram_rdata;
    t_entry                           rd;

    logic [AW-1:0]                    in_base;
    logic [AW-1:0]                    slot;
    logic                             hit;
    logic                             last;
    logic                             finish;
    logic                             accept;

    bhi_ram #(
        .WIDTH  (EW),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd      = t_entry'(ram_rdata);
    assign in_base = AW'({i_key_0[HASH_LSB +: BUCKET_BITS], 3'b000});
    assign slot    = r_base + AW'(r_chk);
    assign hit     = rd.valid && (rd.key == r_key);
    assign last    = (r_mode == MODE_INSERT) ? (r_chk == CW'(INSERT_PROBES - 1))
                                             : (r_chk == CW'(LOOKUP_PROBES - 1));
    assign finish  = (r_mode == MODE_INSERT) ? (!rd.valid || last)
                                             : (!rd.valid || hit || last);
    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = '{valid: 1'b1, key: r_key, fnum: r_fnum, foff: r_foff};
        ram_raddr = last ? slot : (slot + AW'(1));
        n_done    = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_fn_out  = r_fn_out;
        n_fo_out  = r_fo_out;
        n_crowded = r_crowded;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_raddr = in_base;
            end
            S_PROBE: begin
                if (finish) begin
                    n_done    = 1'b1;
                    n_slot    = '0;
                    n_fn_out  = '0;
                    n_fo_out  = '0;
                    n_crowded = 1'b0;
                    if (r_mode == MODE_INSERT) begin
                        if (!rd.valid) begin
                            ram_we    = 1'b1;
                            n_status  = ST_INSERTED;
                            n_slot    = SLOT_W'(slot);
                            n_crowded = (32'(r_chk) >= WARN_PROBE);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else if (hit) begin
                        n_status = ST_FOUND;
                        n_slot   = SLOT_W'(slot);
                        n_fn_out = rd.fnum;
                        n_fo_out = rd.foff;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_chk   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept) begin
                r_chk <= '0;
            end else if (r_state == S_PROBE && !finish) begin
                r_chk <= r_chk + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= {i_key_3, i_key_2, i_key_1, i_key_0};
            r_fnum <= i_file_number;
            r_foff <= i_file_offset;
            r_base <= in_base;
        end
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_fn_out  <= n_fn_out;
        r_fo_out  <= n_fo_out;
        r_crowded <= n_crowded;
    end

    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_slot_index        = r_slot;
    assign o_found_file_number = r_fn_out;
    assign o_found_file_offset = r_fo_out;
    assign o_crowded           = r_crowded;

    `BHI_ASSERT(a_done_after_probe, i_clk, i_rst_n, o_done |-> $past(r_state) == S_PROBE, "result strobe without a probe run")
    `BHI_ASSERT(a_we_legal, i_clk, i_rst_n, ram_we |-> (r_state == S_CLEAR) || (r_state == S_PROBE && r_mode == MODE_INSERT && !rd.valid), "table write outside clear or insert")
    `BHI_ASSERT(a_accept_probe, i_clk, i_rst_n, accept |=> (r_state == S_PROBE && r_chk == '0), "transfer did not start a probe run")
    `BHI_ASSERT(a_crowded_insert, i_clk, i_rst_n, (o_done && o_crowded) |-> o_status == ST_INSERTED, "crowded flag on a non-insert result")
    `BHI_ASSERT(a_probe_bound, i_clk, i_rst_n, (r_state == S_PROBE) |-> (32'(r_chk) < MAX_PROBES), "probe count beyond run length")

endmodule
